### design/bilinear_height_map_correction_unit_assert.svh
// Assertion macros used by the checker file of the height map correction unit.
`ifndef BILINEAR_HEIGHT_MAP_CORRECTION_UNIT_ASSERT_SVH
`define BILINEAR_HEIGHT_MAP_CORRECTION_UNIT_ASSERT_SVH

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define HMC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("height map correction check failed");

// The condition holds in every cycle outside reset.
`define HMC_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("height map correction invariant failed");

`endif

### design/hmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hmc_pkg;

  localparam int DATA_W          = 32;
  localparam int FRAC_W          = 16;
  localparam int GRID_AW         = 10;
  localparam int GRID_DEPTH      = 1 << GRID_AW;
  localparam int COUNT_W         = 6;
  localparam int SPACE_W         = 31;
  localparam int CFG_AW          = 3;
  localparam int DEF_MAX_COLUMNS = 32;
  localparam int DEF_MAX_ROWS    = 32;

  localparam logic [SPACE_W-1:0] SPACE_RESET = SPACE_W'(65536);

  typedef enum logic [CFG_AW-1:0] {
    CFG_COLUMNS     = 3'd0,
    CFG_ROWS        = 3'd1,
    CFG_ORIGIN_X    = 3'd2,
    CFG_ORIGIN_Y    = 3'd3,
    CFG_CELL_WIDTH  = 3'd4,
    CFG_CELL_HEIGHT = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic [GRID_AW-1:0]        grid_index;
    logic signed [DATA_W-1:0]  grid_value;
    logic signed [DATA_W-1:0]  z_command;
    logic signed [DATA_W-1:0]  z_feedback;
    logic                      apply;
    logic                      pass;
  } side_t;

  // Index width shared by both axes.
  function automatic int idx_bits(int max_c, int max_r);
    return $clog2((max_c > max_r) ? max_c : max_r);
  endfunction

  // Cycles from an accepted word to the cell indices and fractions.
  function automatic int loc_latency(int max_c, int max_r);
    return idx_bits(max_c, max_r) + FRAC_W + 3;
  endfunction

  // Cycles from an accepted word to its result strobe.
  function automatic int pipe_latency(int max_c, int max_r);
    return loc_latency(max_c, max_r) + 7;
  endfunction

  function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] n, int max_n);
    return (int'(n) > max_n) ? COUNT_W'(max_n) : n;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_add(logic signed [DATA_W-1:0] a,
                                                       logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_sub(logic signed [DATA_W-1:0] a,
                                                       logic signed [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/bilinear_height_map_correction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Z height map correction with bilinear interpolation over a grid of heights.
// A word is taken at each rising edge where start is high and busy is low;
// busy is high only during reset, so one word can enter every cycle.
// A load word (op low) writes grid_value at grid_index and gives no result.
// A sample word (op high) gives one result: z_out, z_offset and feedback_out
// are shown for exactly one cycle together with done.
// Throughput is one word per cycle; the depth is set by the cell divider,
// which resolves one quotient bit per pipeline stage for the index and
// fraction. Loads and samples keep their order: a load writes the grid at
// the same stage where samples read it. Configuration is written through
// cfg_we, cfg_index and cfg_data; the user must do so only while no word is
// in flight, which the block does not enforce. Reset clears the pipeline
// and the registers; grid contents are undefined until loaded. The
// receiver cannot stall.
module bilinear_height_map_correction_unit
  import hmc_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      op,
  input  wire logic [GRID_AW-1:0]        grid_index,
  input  wire logic signed [DATA_W-1:0]  grid_value,
  input  wire logic signed [DATA_W-1:0]  pos_x,
  input  wire logic signed [DATA_W-1:0]  pos_y,
  input  wire logic signed [DATA_W-1:0]  z_command,
  input  wire logic signed [DATA_W-1:0]  z_feedback,
  input  wire logic                      apply_on,
  input  wire logic                      apply_off,
  output logic                           done,
  output logic signed [DATA_W-1:0]       z_out,
  output logic signed [DATA_W-1:0]       z_offset,
  output logic signed [DATA_W-1:0]       feedback_out,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_AW-1:0]         cfg_index,
  input  wire logic [DATA_W-1:0]         cfg_data
);

  localparam int IDX_W   = idx_bits(MAX_COLUMNS, MAX_ROWS);
  localparam int LOC_LAT = loc_latency(MAX_COLUMNS, MAX_ROWS);
  localparam int PIPE    = pipe_latency(MAX_COLUMNS, MAX_ROWS) - 1;
  localparam int ADDR_ST = LOC_LAT + 1;
  localparam int MW      = IDX_W + COUNT_W + 1;

  logic [COUNT_W-1:0]       columns_used;
  logic [COUNT_W-1:0]       rows_used;
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic [SPACE_W-1:0]       cell_width;
  logic [SPACE_W-1:0]       cell_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_used <= '0;
      rows_used    <= '0;
      origin_x     <= '0;
      origin_y     <= '0;
      cell_width   <= SPACE_RESET;
      cell_height  <= SPACE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_COLUMNS:     columns_used <= cfg_data[COUNT_W-1:0];
        CFG_ROWS:        rows_used    <= cfg_data[COUNT_W-1:0];
        CFG_ORIGIN_X:    origin_x     <= cfg_data;
        CFG_ORIGIN_Y:    origin_y     <= cfg_data;
        CFG_CELL_WIDTH:  cell_width   <= cfg_data[SPACE_W-1:0];
        CFG_CELL_HEIGHT: cell_height  <= cfg_data[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // Word sideband that travels beside the datapath.
  logic  vld  [1:PIPE];
  side_t side [1:PIPE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= PIPE; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[1] <= start && !busy;
      for (int i = 2; i <= PIPE; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side[1].op         <= op_t'(op);
    side[1].grid_index <= grid_index;
    side[1].grid_value <= grid_value;
    side[1].z_command  <= z_command;
    side[1].z_feedback <= z_feedback;
    side[1].apply      <= apply_on && !apply_off;
    side[1].pass       <= (columns_used == '0) || (rows_used == '0);
    for (int i = 2; i <= PIPE; i++) begin
      side[i] <= side[i-1];
    end
  end

  logic [IDX_W-1:0]  ix_lo, ix_hi, iy_lo, iy_hi;
  logic [FRAC_W-1:0] tx, ty;

  hmc_locate #(.MAX_N(MAX_COLUMNS), .IDX_W(IDX_W)) u_loc_x (
    .clk(clk), .pos(pos_x), .origin(origin_x), .spacing(cell_width),
    .count(columns_used), .lo(ix_lo), .hi(ix_hi), .frac(tx)
  );

  hmc_locate #(.MAX_N(MAX_ROWS), .IDX_W(IDX_W)) u_loc_y (
    .clk(clk), .pos(pos_y), .origin(origin_y), .spacing(cell_height),
    .count(rows_used), .lo(iy_lo), .hi(iy_hi), .frac(ty)
  );

  logic [COUNT_W-1:0] ncx;
  logic [MW-1:0]      row0, row1;
  logic [GRID_AW-1:0] addr00, addr01, addr10, addr11;

  assign ncx  = clamp_count(columns_used, MAX_COLUMNS);
  assign row0 = MW'(iy_lo) * MW'(ncx);
  assign row1 = MW'(iy_hi) * MW'(ncx);

  always_ff @(posedge clk) begin
    addr00 <= GRID_AW'(row0 + MW'(ix_lo));
    addr01 <= GRID_AW'(row0 + MW'(ix_hi));
    addr10 <= GRID_AW'(row1 + MW'(ix_lo));
    addr11 <= GRID_AW'(row1 + MW'(ix_hi));
  end

  logic [FRAC_W-1:0] tx_d [1:2];
  logic [FRAC_W-1:0] ty_d [1:4];

  always_ff @(posedge clk) begin
    tx_d[1] <= tx;
    tx_d[2] <= tx_d[1];
    ty_d[1] <= ty;
    for (int i = 2; i <= 4; i++) begin
      ty_d[i] <= ty_d[i-1];
    end
  end

  // Four copies of the grid give the four corner reads in the same cycle.
  logic                     grid_we;
  logic [DATA_W-1:0]        q00, q01, q10, q11;

  assign grid_we = vld[ADDR_ST] && (side[ADDR_ST].op == OP_LOAD);

  hmc_ram #(.WIDTH(DATA_W), .DEPTH(GRID_DEPTH)) u_ram00 (
    .clk(clk), .we(grid_we), .waddr(side[ADDR_ST].grid_index),
    .wdata(side[ADDR_ST].grid_value), .raddr(addr00), .rdata(q00)
  );
  hmc_ram #(.WIDTH(DATA_W), .DEPTH(GRID_DEPTH)) u_ram01 (
    .clk(clk), .we(grid_we), .waddr(side[ADDR_ST].grid_index),
    .wdata(side[ADDR_ST].grid_value), .raddr(addr01), .rdata(q01)
  );
  hmc_ram #(.WIDTH(DATA_W), .DEPTH(GRID_DEPTH)) u_ram10 (
    .clk(clk), .we(grid_we), .waddr(side[ADDR_ST].grid_index),
    .wdata(side[ADDR_ST].grid_value), .raddr(addr10), .rdata(q10)
  );
  hmc_ram #(.WIDTH(DATA_W), .DEPTH(GRID_DEPTH)) u_ram11 (
    .clk(clk), .we(grid_we), .waddr(side[ADDR_ST].grid_index),
    .wdata(side[ADDR_ST].grid_value), .raddr(addr11), .rdata(q11)
  );

  logic signed [DATA_W-1:0] r0, r1, y_off;

  hmc_lerp u_lerp_r0 (.clk(clk), .a(q00), .b(q01), .frac(tx_d[2]), .y(r0));
  hmc_lerp u_lerp_r1 (.clk(clk), .a(q10), .b(q11), .frac(tx_d[2]), .y(r1));
  hmc_lerp u_lerp_y  (.clk(clk), .a(r0),  .b(r1),  .frac(ty_d[4]), .y(y_off));

  logic signed [DATA_W-1:0] offset, applied;

  assign offset  = side[PIPE].pass ? '0 : y_off;
  assign applied = side[PIPE].apply ? offset : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[PIPE] && (side[PIPE].op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    z_out        <= sat_add(side[PIPE].z_command, applied);
    z_offset     <= offset;
    feedback_out <= sat_sub(side[PIPE].z_feedback, applied);
  end

endmodule
`default_nettype wire

### design/hmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module hmc_ram
  import hmc_pkg::*;
#(
  parameter int WIDTH = DATA_W,
  parameter int DEPTH = GRID_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/hmc_locate.sv
`timescale 1ns / 1ps
`default_nettype none
module hmc_locate
  import hmc_pkg::*;
#(
  parameter int MAX_N = DEF_MAX_COLUMNS,
  parameter int IDX_W = idx_bits(DEF_MAX_COLUMNS, DEF_MAX_ROWS)
) (
  input  wire logic                      clk,
  input  wire logic signed [DATA_W-1:0]  pos,
  input  wire logic signed [DATA_W-1:0]  origin,
  input  wire logic [SPACE_W-1:0]        spacing,
  input  wire logic [COUNT_W-1:0]        count,
  output logic [IDX_W-1:0]               lo,
  output logic [IDX_W-1:0]               hi,
  output logic [FRAC_W-1:0]              frac
);

  localparam int QW  = IDX_W + FRAC_W;
  localparam int SPW = SPACE_W + IDX_W;

  logic [SPACE_W-1:0] sp;
  logic [COUNT_W-1:0] ncl;
  logic [IDX_W-1:0]   nm1;
  logic [DATA_W:0]    d;
  logic [SPW-1:0]     span;

  // Spacing of zero counts as one; the user must keep config stable while words are in flight.
  assign sp  = (spacing == '0) ? SPACE_W'(1) : spacing;
  assign ncl = clamp_count(count, MAX_N);
  assign nm1 = IDX_W'(ncl) - IDX_W'(1);

  always_ff @(posedge clk) begin
    d    <= {pos[DATA_W-1], pos} - {origin[DATA_W-1], origin};
    span <= SPW'(sp) * SPW'(nm1);
  end

  logic [SPACE_W-1:0] rem [0:QW];
  logic [QW-1:0]      quo [0:QW];
  logic [IDX_W-1:0]   dlo [0:QW];
  logic               inr [0:QW];
  logic               blw [0:QW];

  // The quotient of (d << 16) / spacing is known to fit the index and fraction
  // bits whenever the position lies inside the grid, so the division starts
  // with the top of d as its partial remainder.
  always_ff @(posedge clk) begin
    rem[0] <= SPACE_W'(d[DATA_W-1:0] >> IDX_W);
    quo[0] <= '0;
    dlo[0] <= d[IDX_W-1:0];
    blw[0] <= d[DATA_W];
    inr[0] <= !d[DATA_W] && (SPW'(d[DATA_W-1:0]) < span);
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int K = QW - 1 - s;
    logic                nb;
    logic [SPACE_W:0]    trial;
    logic                ge;
    logic [QW-1:0]       qn;

    if (K >= FRAC_W) begin : g_num
      assign nb = dlo[s][K-FRAC_W];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign trial = {rem[s], nb};
    assign ge    = trial >= {1'b0, sp};

    always_comb begin
      qn    = quo[s];
      qn[K] = ge;
    end

    always_ff @(posedge clk) begin
      rem[s+1] <= ge ? SPACE_W'(trial - {1'b0, sp}) : trial[SPACE_W-1:0];
      quo[s+1] <= qn;
      dlo[s+1] <= dlo[s];
      inr[s+1] <= inr[s];
      blw[s+1] <= blw[s];
    end
  end

  always_ff @(posedge clk) begin
    if (inr[QW]) begin
      lo   <= quo[QW][QW-1:FRAC_W];
      hi   <= quo[QW][QW-1:FRAC_W] + IDX_W'(1);
      frac <= quo[QW][FRAC_W-1:0];
    end else if (blw[QW]) begin
      lo   <= '0;
      hi   <= '0;
      frac <= '0;
    end else begin
      lo   <= nm1;
      hi   <= nm1;
      frac <= '0;
    end
  end

endmodule
`default_nettype wire

### design/hmc_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
module hmc_lerp
  import hmc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [DATA_W-1:0]  a,
  input  wire logic signed [DATA_W-1:0]  b,
  input  wire logic [FRAC_W-1:0]         frac,
  output logic signed [DATA_W-1:0]       y
);

  localparam int PW = DATA_W + FRAC_W + 2;

  logic signed [DATA_W:0]   diff;
  logic signed [PW-1:0]     prod;
  logic signed [DATA_W-1:0] a_d;
  logic signed [PW-1:0]     rnd;
  logic signed [PW-1:0]     sh;

  assign diff = {b[DATA_W-1], b} - {a[DATA_W-1], a};

  always_ff @(posedge clk) begin
    prod <= PW'(diff * $signed({1'b0, frac}));
    a_d  <= a;
  end

  // a + round((b - a) * t / 2^16) with ties upward; the result always lies
  // between a and b, so the low word of the sum is exact.
  assign rnd = prod + PW'(1 << (FRAC_W - 1));
  assign sh  = rnd >>> FRAC_W;

  always_ff @(posedge clk) begin
    y <= a_d + sh[DATA_W-1:0];
  end

endmodule
`default_nettype wire

### design/hmc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_height_map_correction_unit_assert.svh"
module hmc_checker
  import hmc_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      op,
  input wire logic                      apply_on,
  input wire logic                      apply_off,
  input wire logic signed [DATA_W-1:0]  z_command,
  input wire logic signed [DATA_W-1:0]  z_feedback,
  input wire logic                      done,
  input wire logic signed [DATA_W-1:0]  z_out,
  input wire logic signed [DATA_W-1:0]  feedback_out
);

  localparam int LAT = pipe_latency(MAX_COLUMNS, MAX_ROWS);
  localparam int CW  = $clog2(LAT + 1);

  logic [CW-1:0] since_rst;
  logic          settled;
  logic          take_sample;
  logic          no_apply;

  // Counts cycles since reset so that history checks only look past it.
  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CW'(LAT)) begin
      since_rst <= since_rst + CW'(1);
    end
  end

  assign settled     = since_rst == CW'(LAT);
  assign take_sample = start && !busy && (op == OP_SAMPLE);
  assign no_apply    = apply_off || !apply_on;

  `HMC_ASSERT_IMP(a_sample_gives_result, clk, rst, settled && $past(take_sample, LAT), done)
  `HMC_ASSERT_IMP(a_result_has_sample, clk, rst, settled && done, $past(take_sample, LAT))
  `HMC_ASSERT_IMP(a_unapplied_passes, clk, rst, settled && done && $past(no_apply, LAT), (z_out == $past(z_command, LAT)) && (feedback_out == $past(z_feedback, LAT)))
  `HMC_ASSERT_ALWAYS(a_busy_only_in_reset, clk, rst, !busy)

endmodule

bind bilinear_height_map_correction_unit hmc_checker #(
  .MAX_COLUMNS(MAX_COLUMNS),
  .MAX_ROWS(MAX_ROWS)
) u_hmc_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
  .apply_on(apply_on), .apply_off(apply_off), .z_command(z_command),
  .z_feedback(z_feedback), .done(done), .z_out(z_out), .feedback_out(feedback_out)
);
`default_nettype wire
